/* rtl/cpf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_pkg: shared definitions for the complementary pitch filter
// Fixed-point constants, datapath operation codes, the controller/datapath
// command and status types, and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package cpf_pkg;

    // field and register widths
    localparam int ACC_W    = 16;
    localparam int PITCH_W  = 17;
    localparam int WEIGHT_W = 17;
    localparam int BIAS_W   = 16;
    localparam int CFG_IDX_W = 8;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS    = 8'd1;
    localparam logic [WEIGHT_W-1:0]  BLEND_RESET      = 17'd64225;
    localparam logic [WEIGHT_W-1:0]  ALPHA_ONE        = 17'd65536;

    // limits in 1/256 degree
    localparam int PITCH_LIMIT = 46080;
    localparam int ACCEL_LIMIT = 23040;

    // CORDIC
    localparam int CORDIC_MAX     = 24;
    localparam int CORDIC_STEPS_D = 16;
    localparam int IDX_W          = 5;

    // shared multiplier operands and product
    localparam int MUL_W  = 20;
    localparam int PROD_W = 40;
    localparam int PRED_W = 38;
    localparam int NUM_W  = 56;

    // blend scaling: one microsecond step is 1/500000 of the rate unit
    localparam logic signed [MUL_W-1:0] US_SCALE = 20'sd500000;
    localparam longint DEN_L = 64'd65536 * 64'd500000;
    localparam int QUOT_W = 18;
    localparam longint QUOT_OFFSET_L = 64'd1 << (QUOT_W - 1);
    // half of the divisor for rounding plus an offset that keeps the dividend positive
    localparam logic signed [NUM_W-1:0] DIV_BIAS = NUM_W'(DEN_L / 2 + DEN_L * QUOT_OFFSET_L);
    localparam logic signed [QUOT_W:0] QUOT_OFFSET = (QUOT_W+1)'(QUOT_OFFSET_L);

    // divisor 65536 * 500000 = 2^21 * 15625: shift out 2^21, then multiply by
    // ceil(2^45 / 15625), which is exact for any 32-bit shifted dividend
    localparam int          DIV_SHIFT   = 21;
    localparam int          RECIP_SHIFT = 45;
    localparam logic [31:0] RECIP       = 32'd2251799814;

    // datapath operation codes
    typedef logic [4:0] cpf_op_t;
    localparam cpf_op_t OP_NONE     = 5'd0;
    localparam cpf_op_t OP_LOAD     = 5'd1;
    localparam cpf_op_t OP_SQ_X     = 5'd2;
    localparam cpf_op_t OP_SQ_Z     = 5'd3;
    localparam cpf_op_t OP_SQ_ADD   = 5'd4;
    localparam cpf_op_t OP_ISQRT    = 5'd5;
    localparam cpf_op_t OP_CINIT    = 5'd6;
    localparam cpf_op_t OP_CORDIC   = 5'd7;
    localparam cpf_op_t OP_ROUND    = 5'd8;
    localparam cpf_op_t OP_PRED_P   = 5'd9;
    localparam cpf_op_t OP_PRED_R   = 5'd10;
    localparam cpf_op_t OP_PRED_A   = 5'd11;
    localparam cpf_op_t OP_DIFF     = 5'd12;
    localparam cpf_op_t OP_MUL_HI   = 5'd13;
    localparam cpf_op_t OP_MUL_LO   = 5'd14;
    localparam cpf_op_t OP_NUM      = 5'd15;
    localparam cpf_op_t OP_DIV      = 5'd16;
    localparam cpf_op_t OP_QUOT     = 5'd17;
    localparam cpf_op_t OP_FINISH   = 5'd18;

    typedef struct packed {
        cpf_op_t            op;
        logic [IDX_W-1:0]   idx;
    } cpf_cmd_t;

    typedef struct packed {
        logic blend;   // item is a normal update, not an init
    } cpf_status_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [24:0] cpf_atan(input logic [IDX_W-1:0] i);
        logic signed [24:0] v;
        case (i)
            5'd0:  v = 25'sd2949120;
            5'd1:  v = 25'sd1740967;
            5'd2:  v = 25'sd919879;
            5'd3:  v = 25'sd466945;
            5'd4:  v = 25'sd234379;
            5'd5:  v = 25'sd117304;
            5'd6:  v = 25'sd58666;
            5'd7:  v = 25'sd29335;
            5'd8:  v = 25'sd14668;
            5'd9:  v = 25'sd7334;
            5'd10: v = 25'sd3667;
            5'd11: v = 25'sd1833;
            5'd12: v = 25'sd917;
            5'd13: v = 25'sd458;
            5'd14: v = 25'sd229;
            5'd15: v = 25'sd115;
            5'd16: v = 25'sd57;
            5'd17: v = 25'sd29;
            5'd18: v = 25'sd14;
            5'd19: v = 25'sd7;
            5'd20: v = 25'sd4;
            5'd21: v = 25'sd2;
            5'd22: v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/complementary_pitch_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// complementary_pitch_filter: IMU pitch from accelerometer and gyro
// Input items arrive on the s_ stream, one result item leaves on the m_
// stream for each. Configuration writes (blend_weight at index 0,
// gyro_bias at index 1) use the cfg_ channel, always ready; write only
// while no item is in flight.
// An item passes 16 square root steps and CORDIC_STEPS passes of the
// shared CORDIC stage; an update item uses seven steps on the shared
// multiplier (an init item two) and a one-step reciprocal divide. One item
// is in work at a time; s_tready is high only while the sequencer is idle,
// so with items offered back to back the next one is taken only once the
// one before has been finished.
// The result is held in an output register; a stalled receiver holds it
// and the next item may be accepted and worked on meanwhile, waiting at
// the end until the register is taken.
// Reset restores blend_weight 64225, gyro_bias 0 and a zero pitch estimate.
// ----------------------------------------------------------------------------
module complementary_pitch_filter #(
    parameter int CORDIC_STEPS = cpf_pkg::CORDIC_STEPS_D
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // accel_x, accel_y, accel_z, gyro_rate, dt_us
    input  wire logic [cpf_pkg::S_DATA_W-1:0]       s_tdata,
    // kind
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // filtered_pitch, accel_pitch, zero fill
    output logic [cpf_pkg::M_DATA_W-1:0]            m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cpf_pkg::WEIGHT_W-1:0]       cfg_data
);
    import cpf_pkg::*;

    cpf_cmd_t    cmd;
    cpf_status_t status;

    assign cfg_ready = 1'b1;

    cpf_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cpf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

/* rtl/cpf_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_ctrl: sequencer for the complementary pitch filter
// Walks an item through square, square root, CORDIC and, for an update,
// blend and divide steps, and owns the input/output handshakes.
// ----------------------------------------------------------------------------
module cpf_ctrl #(
    parameter int CORDIC_STEPS = cpf_pkg::CORDIC_STEPS_D
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire cpf_pkg::cpf_status_t status,
    output cpf_pkg::cpf_cmd_t        cmd
);
    import cpf_pkg::*;

    localparam logic [IDX_W-1:0] CORDIC_LAST = IDX_W'(CORDIC_STEPS - 1);
    localparam logic [IDX_W-1:0] ISQRT_FIRST = 5'd15;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_SQ_X   = 5'd1;
    localparam logic [4:0] ST_SQ_Z   = 5'd2;
    localparam logic [4:0] ST_SQ_ADD = 5'd3;
    localparam logic [4:0] ST_ISQRT  = 5'd4;
    localparam logic [4:0] ST_CINIT  = 5'd5;
    localparam logic [4:0] ST_CORDIC = 5'd6;
    localparam logic [4:0] ST_ROUND  = 5'd7;
    localparam logic [4:0] ST_PRED_P = 5'd8;
    localparam logic [4:0] ST_PRED_R = 5'd9;
    localparam logic [4:0] ST_PRED_A = 5'd10;
    localparam logic [4:0] ST_DIFF   = 5'd11;
    localparam logic [4:0] ST_MUL_HI = 5'd12;
    localparam logic [4:0] ST_MUL_LO = 5'd13;
    localparam logic [4:0] ST_NUM    = 5'd14;
    localparam logic [4:0] ST_DIV    = 5'd15;
    localparam logic [4:0] ST_QUOT   = 5'd16;
    localparam logic [4:0] ST_FIN    = 5'd17;

    logic [4:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // next-state and command decode
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.op         = OP_NONE;
        cmd.idx        = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_SQ_X;
                end
            end
            ST_SQ_X: begin
                cmd.op     = OP_SQ_X;
                state_next = ST_SQ_Z;
            end
            ST_SQ_Z: begin
                cmd.op     = OP_SQ_Z;
                state_next = ST_SQ_ADD;
            end
            ST_SQ_ADD: begin
                cmd.op     = OP_SQ_ADD;
                idx_next   = ISQRT_FIRST;
                state_next = ST_ISQRT;
            end
            ST_ISQRT: begin
                cmd.op   = OP_ISQRT;
                idx_next = idx_reg - 5'd1;
                if (idx_reg == '0) begin
                    state_next = ST_CINIT;
                end
            end
            ST_CINIT: begin
                cmd.op     = OP_CINIT;
                idx_next   = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.op   = OP_CORDIC;
                idx_next = idx_reg + 5'd1;
                if (idx_reg == CORDIC_LAST) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.op     = OP_ROUND;
                state_next = status.blend ? ST_PRED_P : ST_FIN;
            end
            ST_PRED_P: begin
                cmd.op     = OP_PRED_P;
                state_next = ST_PRED_R;
            end
            ST_PRED_R: begin
                cmd.op     = OP_PRED_R;
                state_next = ST_PRED_A;
            end
            ST_PRED_A: begin
                cmd.op     = OP_PRED_A;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.op     = OP_DIFF;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.op     = OP_MUL_HI;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.op     = OP_MUL_LO;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                cmd.op     = OP_NUM;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op     = OP_DIV;
                state_next = ST_QUOT;
            end
            ST_QUOT: begin
                cmd.op     = OP_QUOT;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready) begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/cpf_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_datapath: arithmetic for the complementary pitch filter
// One shared 20x20 multiplier, a two-bit-per-step square root, a shared
// CORDIC stage, a shift and reciprocal multiply for the divide by the blend
// scale, the configuration registers, the pitch state and the output register.
// ----------------------------------------------------------------------------
module cpf_datapath (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire cpf_pkg::cpf_cmd_t                    cmd,
    output cpf_pkg::cpf_status_t                      status,
    input  wire logic                                 s_tuser,
    input  wire logic [cpf_pkg::S_DATA_W-1:0]         s_tdata,
    input  wire logic                                 cfg_valid,
    input  wire logic [cpf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [cpf_pkg::WEIGHT_W-1:0]         cfg_data,
    output logic [cpf_pkg::M_DATA_W-1:0]              m_tdata
);
    import cpf_pkg::*;

    // input item
    logic signed [15:0]        ax_reg, ay_reg, az_reg;
    logic signed [16:0]        rate_reg;
    logic [15:0]               dt_reg;
    logic                      kind_reg;
    // configuration and state
    logic [WEIGHT_W-1:0]       alpha_reg;
    logic signed [BIAS_W-1:0]  bias_reg;
    logic signed [PITCH_W-1:0] pitch_reg, pitch_next;
    // working registers
    logic signed [PROD_W-1:0]  prod_reg;
    logic [31:0]               sq_reg, sq_next;
    logic [31:0]               res_reg, res_next;
    logic signed [MUL_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [24:0]        z_reg, z_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PITCH_W-1:0] result_reg, result_next;
    logic signed [PRED_W-1:0]  pred_reg, pred_next, diff_reg, diff_next;
    logic signed [NUM_W-1:0]   base_reg, base_next, num_reg, num_next;
    logic [NUM_W-1:0]          rem_reg, rem_next;
    logic [63:0]               recip_reg, recip_next;
    logic signed [PITCH_W-1:0] out_filt_reg, out_filt_next;
    logic signed [ACC_W-1:0]   out_acc_reg, out_acc_next;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic [WEIGHT_W-1:0]       alpha_eff;
    logic [31:0]               sq_bit, sq_trial;
    logic signed [MUL_W-1:0]   xs, ys;
    logic signed [24:0]        atan_v, z_round;
    logic [31:0]               div_in;
    logic signed [QUOT_W:0]    q_signed;

    assign status.blend = kind_reg;
    assign m_tdata = {{(M_DATA_W - PITCH_W - ACC_W){1'b0}}, out_acc_reg, out_filt_reg};
    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ_X: begin
                mul_a = MUL_W'(ax_reg);
                mul_b = MUL_W'(ax_reg);
            end
            OP_SQ_Z: begin
                mul_a = MUL_W'(az_reg);
                mul_b = MUL_W'(az_reg);
            end
            OP_PRED_P: begin
                mul_a = MUL_W'(pitch_reg);
                mul_b = US_SCALE;
            end
            OP_PRED_R: begin
                mul_a = MUL_W'(rate_reg);
                mul_b = $signed({4'b0, dt_reg});
            end
            OP_PRED_A: begin
                mul_a = MUL_W'(acc_reg);
                mul_b = US_SCALE;
            end
            OP_MUL_HI: begin
                mul_a = $signed({3'b0, alpha_eff});
                mul_b = MUL_W'($signed(diff_reg[PRED_W-1:19]));
            end
            OP_MUL_LO: begin
                mul_a = $signed({3'b0, alpha_eff});
                mul_b = $signed({1'b0, diff_reg[18:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // per-step helpers
    always_comb begin
        sq_bit   = 32'd1 << {cmd.idx, 1'b0};
        sq_trial = res_reg + sq_bit;
        xs       = x_reg >>> cmd.idx;
        ys       = y_reg >>> cmd.idx;
        atan_v   = cpf_atan(cmd.idx);
        z_round  = (z_reg + 25'sd128) >>> 8;
        div_in   = rem_reg[DIV_SHIFT+31:DIV_SHIFT];
        q_signed = $signed({1'b0, recip_reg[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT]})
                   - QUOT_OFFSET;
    end

    // working register updates
    always_comb begin
        sq_next       = sq_reg;
        res_next      = res_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        acc_next      = acc_reg;
        result_next   = result_reg;
        pred_next     = pred_reg;
        diff_next     = diff_reg;
        base_next     = base_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        recip_next    = recip_reg;
        pitch_next    = pitch_reg;
        out_filt_next = out_filt_reg;
        out_acc_next  = out_acc_reg;
        case (cmd.op)
            OP_SQ_Z: begin
                sq_next = prod_reg[31:0];
            end
            OP_SQ_ADD: begin
                sq_next  = sq_reg + prod_reg[31:0];
                res_next = '0;
            end
            OP_ISQRT: begin
                if (sq_reg >= sq_trial) begin
                    sq_next  = sq_reg - sq_trial;
                    res_next = (res_reg >> 1) + sq_bit;
                end else begin
                    res_next = res_reg >> 1;
                end
            end
            OP_CINIT: begin
                x_next = $signed({4'b0, res_reg[15:0]});
                y_next = MUL_W'(ay_reg);
                z_next = '0;
            end
            OP_CORDIC: begin
                if (!y_reg[MUL_W-1]) begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_v;
                end else begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_v;
                end
            end
            OP_ROUND: begin
                // a zero Y axis gives a level reading whatever the other axes
                if (ay_reg == '0) begin
                    acc_next = '0;
                end else if (z_round > 25'(ACCEL_LIMIT)) begin
                    acc_next = 16'(ACCEL_LIMIT);
                end else if (z_round < -25'(ACCEL_LIMIT)) begin
                    acc_next = -16'(ACCEL_LIMIT);
                end else begin
                    acc_next = z_round[ACC_W-1:0];
                end
                result_next = PITCH_W'(acc_next);
            end
            OP_PRED_R: begin
                pred_next = PRED_W'(prod_reg);
            end
            OP_PRED_A: begin
                pred_next = pred_reg + PRED_W'(prod_reg);
            end
            OP_DIFF: begin
                base_next = (NUM_W'(prod_reg) <<< 16) + DIV_BIAS;
                diff_next = pred_reg - PRED_W'(prod_reg);
            end
            OP_MUL_LO: begin
                num_next = (NUM_W'(prod_reg) <<< 19) + base_reg;
            end
            OP_NUM: begin
                rem_next = $unsigned(num_reg + NUM_W'(prod_reg));
            end
            OP_DIV: begin
                // floor(rem / 2^21) * ceil(2^45 / 15625), quotient in the top bits
                recip_next = 64'(div_in) * 64'(RECIP);
            end
            OP_QUOT: begin
                if (q_signed > (QUOT_W+1)'(PITCH_LIMIT)) begin
                    result_next = PITCH_W'(PITCH_LIMIT);
                end else if (q_signed < -(QUOT_W+1)'(PITCH_LIMIT)) begin
                    result_next = -PITCH_W'(PITCH_LIMIT);
                end else begin
                    result_next = q_signed[PITCH_W-1:0];
                end
            end
            OP_FINISH: begin
                pitch_next    = result_reg;
                out_filt_next = result_reg;
                out_acc_next  = acc_reg;
            end
            default: begin
                sq_next = sq_reg;
            end
        endcase
    end

    // configuration, state and input capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= BLEND_RESET;
            bias_reg  <= '0;
            pitch_reg <= '0;
        end else begin
            if (cfg_valid && cfg_index == REG_BLEND_WEIGHT) begin
                alpha_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_GYRO_BIAS) begin
                bias_reg <= $signed(cfg_data[BIAS_W-1:0]);
            end
            pitch_reg <= pitch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            kind_reg <= s_tuser;
            ax_reg   <= $signed(s_tdata[15:0]);
            ay_reg   <= $signed(s_tdata[31:16]);
            az_reg   <= $signed(s_tdata[47:32]);
            rate_reg <= 17'($signed(s_tdata[63:48])) - 17'(bias_reg);
            dt_reg   <= s_tdata[79:64];
        end
        prod_reg     <= PROD_W'(mul_a * mul_b);
        sq_reg       <= sq_next;
        res_reg      <= res_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        acc_reg      <= acc_next;
        result_reg   <= result_next;
        pred_reg     <= pred_next;
        diff_reg     <= diff_next;
        base_reg     <= base_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        recip_reg    <= recip_next;
        out_filt_reg <= out_filt_next;
        out_acc_reg  <= out_acc_next;
    end

endmodule
`default_nettype wire

/* rtl/cpf_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_checker: port-level checks for the complementary pitch filter
// Watches the streams for one-at-a-time sequencing, held results and the
// ranges of the result fields.
// ----------------------------------------------------------------------------
module cpf_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [cpf_pkg::M_DATA_W-1:0]  m_tdata
);
    import cpf_pkg::*;

    // an accepted item keeps the input closed while it is worked on
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // filtered pitch saturated to half a turn
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[16:0]) <= 17'sd46080
                  && $signed(m_tdata[16:0]) >= -17'sd46080)
        else $error("filtered pitch out of range");

    // accel pitch within a quarter turn, fill bits zero
    a_accel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[32:17]) <= 16'sd23040
                  && $signed(m_tdata[32:17]) >= -16'sd23040
                  && m_tdata[M_DATA_W-1:33] == '0)
        else $error("accel pitch out of range");

endmodule

bind complementary_pitch_filter cpf_checker u_cpf_checker (.*);
`default_nettype wire
